// ----- design/ftbm_pkg.sv -----
// ----------------------------------------------------------------------------
// ftbm_pkg
// Shared types and constants of the text-layer tile bank mapper.
// ----------------------------------------------------------------------------
package ftbm_pkg;

    // Fixed sizes of the stores.
    localparam int BANK_ROWS   = 32;
    localparam int TABLE_WORDS = 256;
    localparam int TADDR_W     = $clog2(TABLE_WORDS);
    localparam int RADDR_W     = $clog2(BANK_ROWS);

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_TYPE   = 1'd1;

    // Bank type register values.
    localparam logic [1:0] BTYPE_NONE = 2'd0;
    localparam logic [1:0] BTYPE_ROWS = 2'd1;

    // Request commands.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SCAN  = 2'd1;
    localparam logic [1:0] CMD_MAP   = 2'd2;

    // Row marker pattern in the bank table.
    localparam logic [15:0] MARK_WORD = 16'h0200;
    localparam logic [7:0]  MARK_HIGH = 8'hff;

    // Multiplier for column / 6 over a 6-bit column.
    localparam logic [5:0] DIV6_MUL = 6'd43;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  table_index;
        logic [15:0] word;
        logic [5:0]  column;
        logic [4:0]  row;
    } t_req;

    typedef struct packed {
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [13:0] tile_code;
        logic [3:0]  palette;
    } t_res;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SCAN,
        OP_MAP
    } t_op;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_ROWS,
        MODE_PACKED
    } t_mode;

    // One classified operation waiting for the back end.
    typedef struct packed {
        t_op                op;
        t_mode              mode;
        logic [TADDR_W-1:0] tbl_addr;
        logic [15:0]        word;
        logic [RADDR_W-1:0] rb_idx;
        logic [2:0]         field;
        logic [8:0]         pixel_x;
        logic [7:0]         pixel_y;
    } t_entry;

endpackage

// ----- design/ftbm_front.sv -----
// ----------------------------------------------------------------------------
// ftbm_front
// Holds the configuration registers, accepts requests and turns each kept one
// into a classified operation with its addresses already worked out.
// ----------------------------------------------------------------------------
module ftbm_front
    import ftbm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_accept,
    input  t_req                 i_req,
    output logic                 o_push,
    output t_entry               o_entry
);

    logic       r_bank_enable;
    logic [1:0] r_bank_type;
    logic [11:0] div_prod;
    logic [2:0]  col_q;
    logic [5:0]  col_r;
    logic [4:0]  row_m1;
    logic        keep;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_enable <= 1'b0;
            r_bank_type   <= BTYPE_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BANK_ENABLE: r_bank_enable <= i_cfg_data[0];
                CFG_BANK_TYPE:   r_bank_type   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Column split into a group of six and a place within the group.
    assign div_prod = 12'(i_req.column) * 12'(DIV6_MUL);
    assign col_r    = i_req.column - 6'(div_prod[11:8]) * 6'd6;
    assign col_q    = div_prod[10:8];
    assign row_m1   = i_req.row - 5'd1;

    // Classification of the request.
    always_comb begin
        keep            = 1'b0;
        o_entry.op      = OP_MAP;
        o_entry.mode    = MODE_NONE;
        if (r_bank_enable && r_bank_type != BTYPE_NONE) begin
            o_entry.mode = (r_bank_type == BTYPE_ROWS) ? MODE_ROWS : MODE_PACKED;
        end
        unique case (i_req.command)
            CMD_WRITE: begin
                keep       = 1'b1;
                o_entry.op = OP_WRITE;
            end
            CMD_SCAN: begin
                keep       = r_bank_enable && r_bank_type == BTYPE_ROWS;
                o_entry.op = OP_SCAN;
            end
            CMD_MAP: begin
                keep       = 1'b1;
                o_entry.op = OP_MAP;
            end
            default: keep = 1'b0;
        endcase
        // Writes use the given index; packed lookups use the column group.
        if (i_req.command == CMD_WRITE) begin
            o_entry.tbl_addr = i_req.table_index;
        end else begin
            o_entry.tbl_addr = {col_q, row_m1};
        end
        o_entry.word    = i_req.word;
        o_entry.rb_idx  = i_req.row - 5'd2;
        o_entry.field   = 3'(6'd5 - col_r);
        o_entry.pixel_x = {i_req.column, 3'b000};
        o_entry.pixel_y = {i_req.row, 3'b000};
    end

    assign o_push = i_accept && keep;

endmodule

// ----- design/ftbm_queue.sv -----
// ----------------------------------------------------------------------------
// ftbm_queue
// Short first-in first-out queue of classified operations between the
// front end and the back end.
// ----------------------------------------------------------------------------
module ftbm_queue
    import ftbm_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("pop from an empty queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == $past(r_count) + CNT_W'($past(i_push))
                                      - CNT_W'($past(i_pop)))
        else $error("queue fill count lost track");

endmodule

// ----- design/ftbm_back.sv -----
// ----------------------------------------------------------------------------
// ftbm_back
// Carries out queued operations: bank table writes, the frame row scan and
// tile mapping. Owns the bank table memory and the row bank list.
// ----------------------------------------------------------------------------
module ftbm_back
    import ftbm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_entry i_head,
    output logic   o_pop,
    output logic   o_strobe,
    output t_res   o_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_SECOND,
        ST_EVAL
    } t_state;

    localparam int FILL_W = RADDR_W + 1;
    localparam int PAIR_W = RADDR_W;

    logic [15:0]            r_mem [TABLE_WORDS];
    logic [TABLE_WORDS-1:0] r_mem_vld;
    logic [15:0]            r_rd_data;
    logic                   r_rd_vld;
    logic [1:0]             r_row_bank [BANK_ROWS];

    t_state             r_state, n_state;
    logic [PAIR_W-1:0]  r_pair, n_pair;
    logic [FILL_W-1:0]  r_filled, n_filled;
    logic [1:0]         r_bank, n_bank;
    logic               r_first_hit, n_first_hit;
    logic               r_s1_vld;
    t_entry             r_s1;
    logic               r_out_vld;

    logic [TADDR_W-1:0] rd_addr;
    logic [15:0]        rd_val;
    logic               mem_we;
    logic               hit;
    logic               row_we0, row_we1;
    logic [RADDR_W-1:0] row_idx0, row_idx1;
    logic [1:0]         map_bank;
    t_res               map_res;

    assign o_pop  = (r_state == ST_IDLE) && i_valid;
    assign mem_we = o_pop && i_head.op == OP_WRITE;
    assign rd_val = r_rd_vld ? r_rd_data : 16'h0000;

    // Read address: the scan pair words, otherwise the popped lookup.
    always_comb begin
        priority case (r_state)
            ST_RD_FIRST:  rd_addr = {2'b00, r_pair, 1'b0};
            ST_RD_SECOND: rd_addr = {2'b10, r_pair, 1'b0};
            default:      rd_addr = i_head.tbl_addr;
        endcase
    end

    // Bank table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_head.tbl_addr] <= i_head.word;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Written-entry flags; an unwritten entry reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_mem_vld[i_head.tbl_addr] <= 1'b1;
            end
            r_rd_vld <= r_mem_vld[rd_addr];
        end
    end

    // Scan sequencer next state: read a word pair, then evaluate it.
    always_comb begin
        n_state     = r_state;
        n_pair      = r_pair;
        n_filled    = r_filled;
        n_bank      = r_bank;
        n_first_hit = r_first_hit;
        hit         = r_first_hit && rd_val[15:8] == MARK_HIGH;
        row_we0     = 1'b0;
        row_we1     = 1'b0;
        row_idx0    = r_filled[RADDR_W-1:0];
        row_idx1    = r_filled[RADDR_W-1:0] + 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop && i_head.op == OP_SCAN) begin
                    n_state  = ST_RD_FIRST;
                    n_pair   = '0;
                    n_filled = '0;
                    n_bank   = 2'd0;
                end
            end
            ST_RD_FIRST: n_state = ST_RD_SECOND;
            ST_RD_SECOND: begin
                n_first_hit = (rd_val == MARK_WORD);
                n_state     = ST_EVAL;
            end
            ST_EVAL: begin
                row_we0 = 1'b1;
                if (hit) begin
                    n_bank   = rd_val[1:0];
                    row_we1  = (r_filled[RADDR_W-1:0] != RADDR_W'(BANK_ROWS - 1));
                    n_filled = r_filled + FILL_W'(2);
                end else begin
                    n_filled = r_filled + FILL_W'(1);
                end
                n_pair  = r_pair + 1'b1;
                n_state = (n_filled >= FILL_W'(BANK_ROWS)) ? ST_IDLE : ST_RD_FIRST;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pair      <= '0;
            r_filled    <= '0;
            r_bank      <= 2'd0;
            r_first_hit <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pair      <= n_pair;
            r_filled    <= n_filled;
            r_bank      <= n_bank;
            r_first_hit <= n_first_hit;
            r_s1_vld    <= o_pop && i_head.op == OP_MAP;
            r_out_vld   <= r_s1_vld;
        end
        if (o_pop) begin
            r_s1 <= i_head;
        end
        if (r_s1_vld) begin
            o_res <= map_res;
        end
    end

    // Row bank list, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BANK_ROWS; i++) begin
                r_row_bank[i] <= 2'd0;
            end
        end else begin
            if (row_we0) begin
                r_row_bank[row_idx0] <= n_bank;
            end
            if (row_we1) begin
                r_row_bank[row_idx1] <= n_bank;
            end
        end
    end

    // Tile code assembly for the lookup in the cycle after its pop.
    always_comb begin
        unique case (r_s1.field)
            3'd0:    map_bank = rd_val[1:0];
            3'd1:    map_bank = rd_val[3:2];
            3'd2:    map_bank = rd_val[5:4];
            3'd3:    map_bank = rd_val[7:6];
            3'd4:    map_bank = rd_val[9:8];
            3'd5:    map_bank = rd_val[11:10];
            default: map_bank = 2'd0;
        endcase
        if (r_s1.mode == MODE_ROWS) begin
            map_bank = r_row_bank[r_s1.rb_idx];
        end
        map_res.pixel_x = r_s1.pixel_x;
        map_res.pixel_y = r_s1.pixel_y;
        map_res.palette = r_s1.word[15:12];
        if (r_s1.mode == MODE_NONE) begin
            map_res.tile_code = {2'b00, r_s1.word[11:0]};
        end else begin
            map_res.tile_code = {map_bank ^ 2'b11, r_s1.word[11:0]};
        end
    end

    assign o_strobe = r_out_vld;

    a_out_from_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $past(r_s1_vld)) else $error("result without a lookup");
    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_filled < FILL_W'(BANK_ROWS))
        else $error("scan ran past the row list");
    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RD_SECOND |-> !r_s1_vld)
        else $error("lookup overlapped the row scan");

endmodule

// ----- design/fix_layer_tile_bank_mapper_top.sv -----
// ----------------------------------------------------------------------------
// fix_layer_tile_bank_mapper_top
// Text-layer tile bank mapper: maps tile words to 14-bit tile codes whose
// bank bits are inverted when banked; 256-word bank table, 32-row bank list.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         start high, busy low      i_req   (t_req)
//   result    out        o_strobe, one cycle       o_res   (t_res)
//   config    in         i_cfg_we, no wait         i_cfg_index, i_cfg_data
//
// The back end takes a table write or a tile request while staying idle;
// tiles stream at one per cycle while no frame scan holds the back end, with
// the result registered after a table read and then code assembly.
// A frame scan holds the back end for 16 to 32 table word pairs, read word
// by word and bounded by the single memory read port.
// Requests are queued meanwhile; busy rises when the queue is full.
// Reset is synchronous; the bank table reads as zero until written.
// ----------------------------------------------------------------------------
module fix_layer_tile_bank_mapper_top
    import ftbm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_strobe,
    output t_res                 o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic   full;
    logic   push;
    logic   pop;
    logic   head_vld;
    t_entry entry;
    t_entry head;

    assign busy = full;

    // Front end: configuration and request classification.
    ftbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (start && !full),
        .i_req       (i_req),
        .o_push      (push),
        .o_entry     (entry)
    );

    // Queue between the two ends.
    ftbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_vld),
        .o_head  (head)
    );

    // Back end: table memory, row scan and tile mapping.
    ftbm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_vld),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule
